>>> hw/rtl/wua_pkg.sv
// Package: command and status codes and controller/datapath interface types.
package wua_pkg;
  localparam logic [2:0] CMD_CMP = 3'd0;
  localparam logic [2:0] CMD_ADD = 3'd1;
  localparam logic [2:0] CMD_SUB = 3'd2;
  localparam logic [2:0] CMD_MUL = 3'd3;
  localparam logic [2:0] CMD_DIV = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NEG  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  typedef struct packed {
    logic load;   // capture operands, set up iteration
    logic step;   // one multiply or divide bit step
    logic finish; // form result into output register
  } ctl_t;

  typedef struct packed {
    logic [2:0] cmd;
  } sts_t;
endpackage

>>> hw/rtl/wide_unsigned_alu_189bit.sv
// Top level: 189-bit unsigned ALU (compare, add, subtract, multiply, divide).
//
// channel | ports                               | transfer
// input   | in_cmd, in_a_*, in_b_*              | start high and busy low
// result  | out_res_*, out_status               | out_valid high, one cycle
//
// Compare, add and subtract go from start through S_RUN, S_FIN and S_OUT to the strobe.
// Multiply and divide step through all 3*LIMB_BITS operand bits in S_RUN: the
// shared shift-add / shift-subtract unit retires one operand bit a cycle.
// busy stays high until the strobe cycle ends; a new start is taken after.
// Reset is synchronous, active low, and returns the controller to idle.
// The receiver cannot stall: each result shows for exactly one cycle.
module wide_unsigned_alu_189bit #(
  parameter int LIMB_BITS = 63
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           in_cmd,
  input  logic [LIMB_BITS-1:0] in_a_low,
  input  logic [LIMB_BITS-1:0] in_a_mid,
  input  logic [LIMB_BITS-1:0] in_a_high,
  input  logic [LIMB_BITS-1:0] in_b_low,
  input  logic [LIMB_BITS-1:0] in_b_mid,
  input  logic [LIMB_BITS-1:0] in_b_high,
  output logic                 out_valid,
  output logic [LIMB_BITS-1:0] out_res_low,
  output logic [LIMB_BITS-1:0] out_res_mid,
  output logic [LIMB_BITS-1:0] out_res_high,
  output logic [1:0]           out_status
);
  localparam int W = 3 * LIMB_BITS;

  wua_pkg::ctl_t ctl;
  wua_pkg::sts_t sts;
  logic [W-1:0]  res;

  // controller: owns the handshake and the bit counter
  wua_ctrl #(.LIMB_BITS(LIMB_BITS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .sts(sts),
    .ctl(ctl), .busy(busy), .done(out_valid)
  );

  // datapath: limbs join into one wide word, least significant limb lowest
  wua_datapath #(.LIMB_BITS(LIMB_BITS)) u_dp (
    .clk(clk), .ctl(ctl), .in_cmd(in_cmd),
    .in_a({in_a_high, in_a_mid, in_a_low}),
    .in_b({in_b_high, in_b_mid, in_b_low}),
    .sts(sts), .res(res), .res_status(out_status)
  );

  assign out_res_low  = res[LIMB_BITS-1:0];
  assign out_res_mid  = res[2*LIMB_BITS-1:LIMB_BITS];
  assign out_res_high = res[W-1:2*LIMB_BITS];
endmodule

>>> hw/rtl/wua_datapath.sv
// Datapath: operand registers, shift-add/shift-subtract accumulator, result register.
module wua_datapath #(
  parameter int LIMB_BITS = 63
) (
  input  logic                   clk,
  input  wua_pkg::ctl_t          ctl,
  input  logic [2:0]             in_cmd,
  input  logic [3*LIMB_BITS-1:0] in_a,
  input  logic [3*LIMB_BITS-1:0] in_b,
  output wua_pkg::sts_t          sts,
  output logic [3*LIMB_BITS-1:0] res,
  output logic [1:0]             res_status
);
  localparam int W = 3 * LIMB_BITS;

  logic [2:0]   cmd_r;
  logic [W-1:0] a_r, b_r, acc_r, sh_r, q_r;
  logic         lost_r, ovf_r;
  logic [W-1:0] res_r;
  logic [1:0]   st_r;

  // separate adders/subtractors: multiply step, divide step, add and subtract
  logic [W:0]   mul_sum;
  logic [W:0]   rem_sh;
  logic [W+1:0] rem_diff;
  logic         take;
  logic [W:0]   add_full;
  logic [W:0]   sub_full;

  always_comb begin
    mul_sum  = {1'b0, acc_r} + {1'b0, sh_r};
    rem_sh   = {acc_r, a_r[W-1]};
    rem_diff = {1'b0, rem_sh} - {2'b0, b_r};
    take     = !rem_diff[W+1];
    add_full = {1'b0, a_r} + {1'b0, b_r};
    sub_full = {1'b0, a_r} - {1'b0, b_r};
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= in_cmd;
      a_r    <= in_a;
      b_r    <= in_b;
      acc_r  <= '0;
      sh_r   <= in_b;
      q_r    <= '0;
      lost_r <= 1'b0;
      ovf_r  <= 1'b0;
    end else if (ctl.step) begin
      if (cmd_r == wua_pkg::CMD_MUL) begin
        // consume a from the bottom, shift b up
        if (a_r[0]) begin
          acc_r <= mul_sum[W-1:0];
          if (lost_r || mul_sum[W]) ovf_r <= 1'b1;
        end
        if (sh_r[W-1]) lost_r <= 1'b1;
        sh_r <= {sh_r[W-2:0], 1'b0};
        a_r  <= {1'b0, a_r[W-1:1]};
      end else begin
        // consume a from the top, restoring division
        acc_r <= take ? rem_diff[W-1:0] : rem_sh[W-1:0];
        q_r   <= {q_r[W-2:0], take};
        a_r   <= {a_r[W-2:0], 1'b0};
      end
    end
    if (ctl.finish) begin
      case (cmd_r)
        wua_pkg::CMD_CMP: begin
          res_r <= {{(W-1){1'b0}}, (a_r > b_r)};
          st_r  <= wua_pkg::ST_OK;
        end
        wua_pkg::CMD_ADD: begin
          res_r <= add_full[W-1:0];
          st_r  <= add_full[W] ? wua_pkg::ST_OVF : wua_pkg::ST_OK;
        end
        wua_pkg::CMD_SUB: begin
          if (b_r > a_r) begin
            res_r <= a_r;
            st_r  <= wua_pkg::ST_NEG;
          end else begin
            res_r <= sub_full[W-1:0];
            st_r  <= wua_pkg::ST_OK;
          end
        end
        wua_pkg::CMD_MUL: begin
          res_r <= acc_r;
          st_r  <= ovf_r ? wua_pkg::ST_OVF : wua_pkg::ST_OK;
        end
        wua_pkg::CMD_DIV: begin
          if (b_r == '0) begin
            res_r <= '0;
            st_r  <= wua_pkg::ST_DIV0;
          end else begin
            res_r <= q_r;
            st_r  <= wua_pkg::ST_OK;
          end
        end
        default: begin
          res_r <= '0;
          st_r  <= wua_pkg::ST_OK;
        end
      endcase
    end
  end

  assign sts.cmd    = cmd_r;
  assign res        = res_r;
  assign res_status = st_r;
endmodule

>>> hw/rtl/wua_ctrl.sv
// Controller: sequences load, bit steps and result strobe.
module wua_ctrl #(
  parameter int LIMB_BITS = 63
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  wua_pkg::sts_t sts,
  output wua_pkg::ctl_t ctl,
  output logic          busy,
  output logic          done
);
  localparam int W  = 3 * LIMB_BITS;
  localparam int CW = $clog2(W + 1);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN, S_OUT} state_t;
  state_t        state_r;
  logic [CW-1:0] cnt_r;
  logic          iter;

  assign iter       = (sts.cmd == wua_pkg::CMD_MUL) || (sts.cmd == wua_pkg::CMD_DIV);
  assign ctl.load   = start && !busy;
  assign ctl.step   = (state_r == S_RUN) && iter;
  assign ctl.finish = (state_r == S_FIN);
  assign busy       = (state_r != S_IDLE);
  assign done       = (state_r == S_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: if (start) state_r <= S_RUN;
        S_RUN: begin
          if (!iter) begin
            state_r <= S_FIN;
          end else if (cnt_r == CW'(W - 1)) begin
            state_r <= S_FIN;
            cnt_r   <= '0;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_FIN:   state_r <= S_OUT;
        S_OUT:   state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.finish |=> done) else $error("strobe missing after finish");
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !ctl.load) else $error("load while busy");
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done) else $error("strobe held two cycles");
endmodule
